@@ sv/rbfe_pkg.sv @@
// ----------------------------------------------------------------------------
// rbfe_pkg: shared types and constants for the radial blur frame engine
// Frame geometry, opcodes, item structs and sequencer states.
// ----------------------------------------------------------------------------
package rbfe_pkg;

  localparam int unsigned FrameWidth  = 320;
  localparam int unsigned FrameHeight = 200;
  localparam int unsigned Taps        = 8;
  localparam int unsigned HalfW       = FrameWidth / 2;
  localparam int unsigned HalfH       = FrameHeight / 2;
  localparam int unsigned HalfMax     = (HalfW > HalfH) ? HalfW : HalfH;
  localparam int unsigned FrameSize   = FrameWidth * FrameHeight;
  localparam int unsigned AddrW       = 16;
  localparam int unsigned TapW        = $clog2(Taps);
  localparam int unsigned DistW       = $clog2(HalfMax);
  localparam int unsigned OffW        = DistW + TapW;
  localparam int unsigned SumW        = 8 + TapW;
  localparam int unsigned ScaleW      = 17;
  localparam logic [ScaleW-1:0] OneQ16 = ScaleW'(65536);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_BLUR  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [AddrW-1:0] address;
    logic [7:0]       pixel_in;
  } item_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [1:0] done_opcode;
  } item_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_POW,
    ST_OFF,
    ST_TAPRD,
    ST_TAPRD2,
    ST_SAMP,
    ST_SAMPW,
    ST_WR,
    ST_CLR,
    ST_DONE
  } state_e;

endpackage

@@ sv/rbfe_mul.sv @@
// ----------------------------------------------------------------------------
// rbfe_mul: shared registered multiplier
// One 17x17 product a cycle, shifted right by 16 and registered.
// ----------------------------------------------------------------------------
module rbfe_mul (
  input  logic        clk_i,
  input  logic [16:0] a_i,
  input  logic [16:0] b_i,
  output logic [16:0] p_o
);
  import rbfe_pkg::*;

  logic [33:0] prod;
  logic [16:0] p_q;

  // form product and drop fraction
  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= prod[32:16];
  end

  assign p_o = p_q;

endmodule

@@ sv/radial_blur_frame_engine.sv @@
// ----------------------------------------------------------------------------
// radial_blur_frame_engine: 8-tap radial zoom blur over a 320x200 byte frame
// Pixel write, pixel read and in-place blur pass on a single-port frame RAM.
// ----------------------------------------------------------------------------
// Writes and no-ops raise done_o in the cycle after the transfer; reads pass through ST_RDWAIT first.
// A blur pass holds busy through the tap powers, the offset table, then per position
// 8 taps x (2 offset reads + 4 frame reads) + 4 writes, and 2 clears per row; the
// single frame RAM port sets its length.
// The next transfer is taken the cycle after done_o; results cannot be stalled.
// Reset clears control state and sets the scale to 1.0; the frame is not cleared.
module radial_blur_frame_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  rbfe_pkg::item_in_t    item_i,
  output logic                  done_o,
  output rbfe_pkg::item_out_t   result_o,
  input  logic                  cfg_we_i,
  input  logic [16:0]           cfg_wdata_i
);
  import rbfe_pkg::*;

  // registers
  state_e             state_q, state_d;
  item_in_t           item_q, item_d;
  logic [ScaleW-1:0]  scale_q, scale_d;
  logic [16:0]        pow_q [Taps];
  logic [TapW-1:0]    k_q, k_d;
  logic [DistW-1:0]   d_q, d_d;
  logic [DistW-1:0]   dx_q, dx_d;
  logic [DistW-1:0]   dy_q, dy_d;
  logic [1:0]         quad_q, quad_d;
  logic [SumW-1:0]    sum_q [4];
  logic [7:0]         ox_q;
  logic [7:0]         rd_q;
  logic               pow_wr_q, pow_wr_d;
  logic               off_wr_q, off_wr_d;
  logic [OffW-1:0]    off_wa_q, off_wa_d;
  logic               clr_q, clr_d;

  // frame and offset memories
  logic [7:0]         frame_mem [FrameSize];
  logic [7:0]         off_mem   [HalfMax*Taps];
  logic               fr_we;
  logic [AddrW-1:0]   fr_addr;
  logic [7:0]         fr_wdata;
  logic [7:0]         fr_rdata;
  logic [OffW-1:0]    off_ra;
  logic [7:0]         off_rdata;

  // shared multiplier
  logic [16:0]        mul_a, mul_b, mul_p;
  logic [ScaleW-1:0]  scale_sat;

  rbfe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign scale_sat = (scale_q > OneQ16) ? OneQ16 : scale_q;

  // pick multiplier operands
  always_comb begin
    if (state_q == ST_POW) begin
      mul_a = pow_q[k_q];
      mul_b = scale_sat;
    end else begin
      mul_a = 17'(d_q);
      mul_b = pow_q[k_q];
    end
  end

  // quadrant sample, write and clear coordinates; the dy offset stays on off_rdata
  logic [AddrW-1:0] samp_addr, wr_addr, clr_addr;
  logic [9:0]       sx, sy, wx, wy;

  always_comb begin
    sx = ((quad_q == 2'd0) || (quad_q == 2'd3)) ? 10'(HalfW + ox_q) : 10'(HalfW - ox_q);
    sy = quad_q[1] ? 10'(HalfH - off_rdata) : 10'(HalfH + off_rdata);
    wx = ((quad_q == 2'd0) || (quad_q == 2'd3)) ? 10'(HalfW + dx_q) : 10'(HalfW - dx_q);
    wy = quad_q[1] ? 10'(HalfH - dy_q) : 10'(HalfH + dy_q);
    samp_addr = AddrW'(sy) * AddrW'(FrameWidth) + AddrW'(sx);
    wr_addr   = AddrW'(wy) * AddrW'(FrameWidth) + AddrW'(wx);
    clr_addr  = clr_q ? AddrW'((HalfH - dy_q) * FrameWidth)
                      : AddrW'((HalfH + dy_q) * FrameWidth);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (item_i.opcode)
            OP_READ: state_d = ST_RDWAIT;
            OP_BLUR: state_d = ST_POW;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RDWAIT: state_d = ST_DONE;
      ST_POW:    if (pow_wr_q && k_q == TapW'(Taps - 2)) state_d = ST_OFF;
      ST_OFF: begin
        if (off_wr_q && off_wa_q == OffW'(HalfMax*Taps - 1)) state_d = ST_TAPRD;
      end
      ST_TAPRD:  state_d = ST_TAPRD2;
      ST_TAPRD2: state_d = ST_SAMP;
      ST_SAMP:   state_d = ST_SAMPW;
      ST_SAMPW: begin
        if (quad_q == 2'd3)
          state_d = (k_q == TapW'(Taps - 1)) ? ST_WR : ST_TAPRD;
        else
          state_d = ST_SAMP;
      end
      ST_WR: begin
        if (quad_q == 2'd3)
          state_d = (dx_q == DistW'(HalfW - 1)) ? ST_CLR : ST_TAPRD;
      end
      ST_CLR: begin
        if (clr_q)
          state_d = (dy_q == DistW'(HalfH - 1)) ? ST_DONE : ST_TAPRD;
      end
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    item_d   = item_q;
    scale_d  = cfg_we_i ? cfg_wdata_i : scale_q;
    k_d      = k_q;
    d_d      = d_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    quad_d   = quad_q;
    pow_wr_d = 1'b0;
    off_wr_d = 1'b0;
    off_wa_d = off_wa_q;
    clr_d    = clr_q;
    fr_we    = 1'b0;
    fr_addr  = item_q.address;
    fr_wdata = item_q.pixel_in;
    off_ra   = {dy_q, k_q};
    unique case (state_q)
      ST_IDLE: begin
        item_d = item_i;
        k_d    = '0;
        d_d    = '0;
        dx_d   = '0;
        dy_d   = '0;
        quad_d = '0;
        clr_d  = 1'b0;
        off_wa_d = '0;
      end
      ST_RDWAIT: ;
      ST_POW: begin
        // issue one product, store it the next cycle, then advance the tap
        pow_wr_d = ~pow_wr_q;
        if (pow_wr_q) begin
          k_d = k_q + 1'b1;
          if (k_q == TapW'(Taps - 2)) k_d = '0;
        end
      end
      ST_OFF: begin
        off_wr_d = 1'b1;
        off_wa_d = {d_q, k_q};
        k_d = k_q + 1'b1;
        if (k_q == TapW'(Taps - 1)) d_d = d_q + 1'b1;
        if (off_wr_q && off_wa_q == OffW'(HalfMax*Taps - 1)) begin
          off_wr_d = 1'b0;
          k_d = '0;
        end
      end
      ST_TAPRD:  off_ra = {dx_q, k_q};
      ST_TAPRD2: ;
      ST_SAMP:   fr_addr = samp_addr;
      ST_SAMPW: begin
        fr_addr = samp_addr;
        quad_d = quad_q + 1'b1;
        if (quad_q == 2'd3) k_d = k_q + 1'b1;
      end
      ST_WR: begin
        fr_we = 1'b1;
        fr_addr = wr_addr;
        fr_wdata = sum_q[quad_q][SumW-1:TapW];
        quad_d = quad_q + 1'b1;
        if (quad_q == 2'd3) dx_d = dx_q + 1'b1;
      end
      ST_CLR: begin
        fr_we = 1'b1;
        fr_addr = clr_addr;
        fr_wdata = '0;
        clr_d = ~clr_q;
        if (clr_q) begin
          dx_d = '0;
          dy_d = dy_q + 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
    if (state_q == ST_IDLE && item_i.opcode == OP_WRITE && start
        && item_i.address < AddrW'(FrameSize)) begin
      fr_we    = 1'b1;
      fr_addr  = item_i.address;
      fr_wdata = item_i.pixel_in;
    end
    if (state_q == ST_IDLE) fr_addr = item_i.address;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      scale_q  <= OneQ16;
      k_q      <= '0;
      d_q      <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      quad_q   <= '0;
      pow_wr_q <= 1'b0;
      off_wr_q <= 1'b0;
      off_wa_q <= '0;
      clr_q    <= 1'b0;
      for (int i = 0; i < Taps; i++) pow_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      scale_q  <= scale_d;
      k_q      <= k_d;
      d_q      <= d_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      quad_q   <= quad_d;
      pow_wr_q <= pow_wr_d;
      off_wr_q <= off_wr_d;
      off_wa_q <= off_wa_d;
      clr_q    <= clr_d;
      // seed tap 0, then store each product into the next tap
      if (state_q == ST_IDLE && start && item_i.opcode == OP_BLUR) pow_q[0] <= OneQ16;
      else if (state_q == ST_POW && pow_wr_q) pow_q[TapW'(k_q + 1'b1)] <= mul_p;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (state_q == ST_TAPRD2) ox_q <= off_rdata;
    // accumulate sample of the current quadrant
    if (state_q == ST_SAMPW) begin
      sum_q[quad_q] <= ((k_q == '0) ? SumW'(0) : sum_q[quad_q]) + SumW'(fr_rdata);
    end
    if (state_q == ST_RDWAIT) rd_q <= fr_rdata;
  end

  // offset table RAM
  always_ff @(posedge clk_i) begin
    if (off_wr_q) off_mem[off_wa_q] <= mul_p[7:0];
    off_rdata <= off_mem[off_ra];
  end

  // frame RAM, read data registered
  always_ff @(posedge clk_i) begin
    if (fr_we) frame_mem[fr_addr] <= fr_wdata;
    fr_rdata <= frame_mem[fr_addr];
  end

  // outputs
  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  always_comb begin
    result_o.done_opcode = item_q.opcode;
    result_o.pixel_out   = (item_q.opcode == OP_READ && item_q.address < AddrW'(FrameSize))
                           ? rd_q : 8'd0;
  end

`ifndef SYNTHESIS
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accept");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done while idle");
`endif

endmodule
